[rtl/kis_pkg.sv]
// Shared types, register codes and helper functions for the inversion step pipeline.
`timescale 1ns / 1ps
`default_nettype none
package kis_pkg;

    localparam logic [2:0] REG_MIN_R2     = 3'd0;
    localparam logic [2:0] REG_CLAMP_GAIN = 3'd1;
    localparam logic [2:0] REG_SCALE      = 3'd2;
    localparam logic [2:0] REG_JULIA      = 3'd3;
    localparam logic [2:0] REG_CMULT      = 3'd4;
    localparam logic [2:0] REG_ROT_X      = 3'd5;
    localparam logic [2:0] REG_ROT_Y      = 3'd6;
    localparam logic [2:0] REG_ROT_Z      = 3'd7;

    localparam int unsigned MODE_ADD   = 32;
    localparam int unsigned MODE_JULIA = 33;
    localparam int unsigned MODE_ROT   = 34;

    localparam logic [31:0] RST_MIN_R2     = 32'd0;
    localparam logic [31:0] RST_CLAMP_GAIN = 32'h0100_0000;
    localparam logic [34:0] RST_SCALE      = 35'h0_0100_0000;
    localparam logic [62:0] RST_JULIA      = 63'd0;
    localparam logic [62:0] RST_CMULT      = 63'h0400_0080_0001_0000;
    localparam logic [62:0] RST_ROT_X      = 63'h0000_0000_0001_0000;
    localparam logic [62:0] RST_ROT_Y      = 63'h0000_0020_0000_0000;
    localparam logic [62:0] RST_ROT_Z      = 63'h0400_0000_0000_0000;

    typedef struct packed {
        logic [31:0] min_r2;
        logic [31:0] clamp_gain;
        logic [34:0] scale_modes;
        logic [62:0] julia;
        logic [62:0] cmult;
        logic [62:0] rot_x;
        logic [62:0] rot_y;
        logic [62:0] rot_z;
    } t_cfg;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [31:0] deriv;
    } t_carry;

    typedef struct packed {
        logic clamped;
        logic neg;
    } t_gctl;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_clip;

    function automatic logic signed [20:0] kis_field(input logic [62:0] p, input int unsigned k);
        return $signed(p[21*k +: 21]);
    endfunction

    function automatic t_clip kis_clip(input logic signed [63:0] v);
        t_clip r;
        if (v > 64'sd2147483647) begin
            r.sat = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r.sat = 1'b1;
            r.val = 32'h8000_0000;
        end else begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/kaliset_inversion_step.sv]
// Top level of the fractal inversion step: register port and the full pipeline.
// The block takes one point per clock cycle while the output does not stall and returns one
// result per point. Three stages form the squared radius, one stage selects the clamp, the
// divider spends one stage per quotient bit over 32 + COORD_FRAC_BITS bits, three stages scale
// the point and derivative, and five stages apply the constant add, julia add and rotation. A
// stall on the output holds the whole pipeline. Registers sit at byte addresses 8*i; the user
// must write them only while no beat is in flight, and the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module kaliset_inversion_step #(
    parameter int COORD_FRAC_BITS = 24
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [5:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [31:0] i_pos_x,
    input  wire  [31:0] i_pos_y,
    input  wire  [31:0] i_pos_z,
    input  wire  [31:0] i_pix_x,
    input  wire  [31:0] i_pix_y,
    input  wire  [31:0] i_pix_z,
    input  wire  [31:0] i_deriv_in,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [31:0] o_new_x,
    output logic [31:0] o_new_y,
    output logic [31:0] o_new_z,
    output logic [31:0] o_deriv_out,
    output logic        o_clamped,
    output logic        o_saturated
);
    localparam int R2W = 64 - COORD_FRAC_BITS;

    kis_pkg::t_cfg   r_cfg;
    logic [2:0]      reg_idx;
    logic            adv;
    logic            rad_valid, div_valid, scl_valid;
    kis_pkg::t_carry rad_carry, div_carry;
    logic [R2W-1:0]  rad_r2;
    kis_pkg::t_gctl  div_ctl;
    logic [31:0]     div_quot, scl_deriv;
    logic            div_ovf, scl_clamped, scl_sat;
    logic [2:0][31:0] scl_v, scl_pix, post_v;

    assign reg_idx = paddr[5:3];
    assign pready  = 1'b1;
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_r2      <= kis_pkg::RST_MIN_R2;
            r_cfg.clamp_gain  <= kis_pkg::RST_CLAMP_GAIN;
            r_cfg.scale_modes <= kis_pkg::RST_SCALE;
            r_cfg.julia       <= kis_pkg::RST_JULIA;
            r_cfg.cmult       <= kis_pkg::RST_CMULT;
            r_cfg.rot_x       <= kis_pkg::RST_ROT_X;
            r_cfg.rot_y       <= kis_pkg::RST_ROT_Y;
            r_cfg.rot_z       <= kis_pkg::RST_ROT_Z;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                kis_pkg::REG_MIN_R2:     r_cfg.min_r2      <= pwdata[31:0];
                kis_pkg::REG_CLAMP_GAIN: r_cfg.clamp_gain  <= pwdata[31:0];
                kis_pkg::REG_SCALE:      r_cfg.scale_modes <= pwdata[34:0];
                kis_pkg::REG_JULIA:      r_cfg.julia       <= pwdata[62:0];
                kis_pkg::REG_CMULT:      r_cfg.cmult       <= pwdata[62:0];
                kis_pkg::REG_ROT_X:      r_cfg.rot_x       <= pwdata[62:0];
                kis_pkg::REG_ROT_Y:      r_cfg.rot_y       <= pwdata[62:0];
                kis_pkg::REG_ROT_Z:      r_cfg.rot_z       <= pwdata[62:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            kis_pkg::REG_MIN_R2:     prdata = 64'(r_cfg.min_r2);
            kis_pkg::REG_CLAMP_GAIN: prdata = 64'(r_cfg.clamp_gain);
            kis_pkg::REG_SCALE:      prdata = 64'(r_cfg.scale_modes);
            kis_pkg::REG_JULIA:      prdata = 64'(r_cfg.julia);
            kis_pkg::REG_CMULT:      prdata = 64'(r_cfg.cmult);
            kis_pkg::REG_ROT_X:      prdata = 64'(r_cfg.rot_x);
            kis_pkg::REG_ROT_Y:      prdata = 64'(r_cfg.rot_y);
            kis_pkg::REG_ROT_Z:      prdata = 64'(r_cfg.rot_z);
            default:                 prdata = '0;
        endcase
    end

    kis_radius #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_radius (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_in_valid),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .i_pix_x (i_pix_x),
        .i_pix_y (i_pix_y),
        .i_pix_z (i_pix_z),
        .i_deriv (i_deriv_in),
        .o_valid (rad_valid),
        .o_carry (rad_carry),
        .o_r2    (rad_r2)
    );

    kis_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (rad_valid),
        .i_carry (rad_carry),
        .i_r2    (rad_r2),
        .i_cfg   (r_cfg),
        .o_valid (div_valid),
        .o_carry (div_carry),
        .o_ctl   (div_ctl),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    kis_scale #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (div_valid),
        .i_carry   (div_carry),
        .i_ctl     (div_ctl),
        .i_quot    (div_quot),
        .i_ovf     (div_ovf),
        .i_cfg     (r_cfg),
        .o_valid   (scl_valid),
        .o_v       (scl_v),
        .o_pix     (scl_pix),
        .o_deriv   (scl_deriv),
        .o_clamped (scl_clamped),
        .o_sat     (scl_sat)
    );

    kis_post #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_post (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (scl_valid),
        .i_v       (scl_v),
        .i_pix     (scl_pix),
        .i_deriv   (scl_deriv),
        .i_clamped (scl_clamped),
        .i_sat     (scl_sat),
        .i_cfg     (r_cfg),
        .o_valid   (o_out_valid),
        .o_v       (post_v),
        .o_deriv   (o_deriv_out),
        .o_clamped (o_clamped),
        .o_sat     (o_saturated)
    );

    assign o_new_x = post_v[0];
    assign o_new_y = post_v[1];
    assign o_new_z = post_v[2];
endmodule
`default_nettype wire

[rtl/kis_radius.sv]
// Absolute-value fold and squared radius, three register stages.
`timescale 1ns / 1ps
`default_nettype none
module kis_radius #(
    parameter int COORD_FRAC_BITS = 24
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_adv,
    input  wire                         i_valid,
    input  wire  [31:0]                 i_pos_x,
    input  wire  [31:0]                 i_pos_y,
    input  wire  [31:0]                 i_pos_z,
    input  wire  [31:0]                 i_pix_x,
    input  wire  [31:0]                 i_pix_y,
    input  wire  [31:0]                 i_pix_z,
    input  wire  [31:0]                 i_deriv,
    output logic                        o_valid,
    output kis_pkg::t_carry             o_carry,
    output logic [63-COORD_FRAC_BITS:0] o_r2
);
    localparam int R2W = 64 - COORD_FRAC_BITS;

    logic            r_s1_valid, r_s2_valid, r_s3_valid;
    kis_pkg::t_carry r_s1_carry, r_s2_carry, r_s3_carry;
    logic [63:0]     r_s2_sq [3];
    logic [R2W-1:0]  r_s3_r2;
    kis_pkg::t_carry n_carry;
    logic [63:0]     n_sum;

    always_comb begin
        n_carry.ax    = i_pos_x[31] ? 32'(-i_pos_x) : i_pos_x;
        n_carry.ay    = i_pos_y[31] ? 32'(-i_pos_y) : i_pos_y;
        n_carry.az    = i_pos_z[31] ? 32'(-i_pos_z) : i_pos_z;
        n_carry.px    = i_pix_x;
        n_carry.py    = i_pix_y;
        n_carry.pz    = i_pix_z;
        n_carry.deriv = i_deriv;
        n_sum = r_s2_sq[0] + r_s2_sq[1] + r_s2_sq[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_carry <= n_carry;
            r_s2_carry <= r_s1_carry;
            r_s2_sq[0] <= 64'(r_s1_carry.ax) * 64'(r_s1_carry.ax);
            r_s2_sq[1] <= 64'(r_s1_carry.ay) * 64'(r_s1_carry.ay);
            r_s2_sq[2] <= 64'(r_s1_carry.az) * 64'(r_s1_carry.az);
            r_s3_carry <= r_s2_carry;
            r_s3_r2    <= R2W'(n_sum >> COORD_FRAC_BITS);
        end
    end

    assign o_valid = r_s3_valid;
    assign o_carry = r_s3_carry;
    assign o_r2    = r_s3_r2;
endmodule
`default_nettype wire

[rtl/kis_div.sv]
// Clamp decision and pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module kis_div #(
    parameter int COORD_FRAC_BITS = 24
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_adv,
    input  wire                         i_valid,
    input  kis_pkg::t_carry             i_carry,
    input  wire  [63-COORD_FRAC_BITS:0] i_r2,
    input  kis_pkg::t_cfg               i_cfg,
    output logic                        o_valid,
    output kis_pkg::t_carry             o_carry,
    output kis_pkg::t_gctl              o_ctl,
    output logic [31:0]                 o_quot,
    output logic                        o_ovf
);
    localparam int R2W = 64 - COORD_FRAC_BITS;
    localparam int RW  = R2W + 1;
    localparam int DW  = 32 + COORD_FRAC_BITS;

    logic            r_v     [DW+1];
    kis_pkg::t_carry r_carry [DW+1];
    kis_pkg::t_gctl  r_ctl   [DW+1];
    logic [DW-1:0]   r_num   [DW+1];
    logic [R2W-1:0]  r_den   [DW+1];
    logic [RW-1:0]   r_rem   [DW+1];
    logic [31:0]     r_q     [DW+1];
    logic            r_ovf   [DW+1];

    kis_pkg::t_gctl  n_ctl;
    logic [31:0]     n_mag;

    always_comb begin
        n_ctl.clamped = 64'(i_r2) < 64'(i_cfg.min_r2);
        n_ctl.neg     = i_cfg.scale_modes[31];
        n_mag = n_ctl.neg ? 32'(-i_cfg.scale_modes[31:0]) : i_cfg.scale_modes[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_carry[0] <= i_carry;
            r_ctl[0]   <= n_ctl;
            r_num[0]   <= {n_mag, {COORD_FRAC_BITS{1'b0}}};
            r_den[0]   <= i_r2;
            r_rem[0]   <= '0;
            r_q[0]     <= '0;
            r_ovf[0]   <= 1'b0;
        end
    end

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic [RW-1:0] n_trial;
        logic          n_ge;

        always_comb begin
            n_trial = {r_rem[k][RW-2:0], r_num[k][DW-1]};
            n_ge    = n_trial >= {1'b0, r_den[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_adv) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_carry[k+1] <= r_carry[k];
                r_ctl[k+1]   <= r_ctl[k];
                r_num[k+1]   <= {r_num[k][DW-2:0], 1'b0};
                r_den[k+1]   <= r_den[k];
                r_rem[k+1]   <= n_ge ? RW'(n_trial - {1'b0, r_den[k]}) : n_trial;
                r_q[k+1]     <= {r_q[k][30:0], n_ge};
                r_ovf[k+1]   <= r_ovf[k] | r_q[k][31];
            end
        end
    end

    assign o_valid = r_v[DW];
    assign o_carry = r_carry[DW];
    assign o_ctl   = r_ctl[DW];
    assign o_quot  = r_q[DW];
    assign o_ovf   = r_ovf[DW];
endmodule
`default_nettype wire

[rtl/kis_scale.sv]
// Gain selection, point scaling and derivative update, three register stages.
`timescale 1ns / 1ps
`default_nettype none
module kis_scale #(
    parameter int COORD_FRAC_BITS = 24
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_adv,
    input  wire              i_valid,
    input  kis_pkg::t_carry  i_carry,
    input  kis_pkg::t_gctl   i_ctl,
    input  wire  [31:0]      i_quot,
    input  wire              i_ovf,
    input  kis_pkg::t_cfg    i_cfg,
    output logic             o_valid,
    output logic [2:0][31:0] o_v,
    output logic [2:0][31:0] o_pix,
    output logic [31:0]      o_deriv,
    output logic             o_clamped,
    output logic             o_sat
);
    logic            r_a_valid, r_b_valid, r_c_valid;
    kis_pkg::t_carry r_a_carry;
    logic [31:0]     r_a_gmag;
    logic            r_a_gneg, r_a_clamped, r_a_sat;
    logic [63:0]     r_b_p [3];
    logic [63:0]     r_b_pd;
    logic [2:0][31:0] r_b_pix, r_c_pix, r_c_v;
    logic            r_b_gneg, r_b_clamped, r_b_sat;
    logic [31:0]     r_c_deriv;
    logic            r_c_clamped, r_c_sat;

    kis_pkg::t_clip       n_clip [3];
    logic signed [64:0]   n_s    [3];
    logic [63:0]          n_d;
    logic                 n_dsat;
    logic [2:0][31:0]     n_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s[i]    = r_b_gneg ? -$signed({1'b0, r_b_p[i]}) : $signed({1'b0, r_b_p[i]});
            n_clip[i] = kis_pkg::kis_clip(64'(n_s[i] >>> COORD_FRAC_BITS));
            n_v[i]    = n_clip[i].val;
        end
        n_d    = (r_b_pd >> COORD_FRAC_BITS) + 64'd65536;
        n_dsat = n_d[63:32] != 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_carry   <= i_carry;
            r_a_gmag    <= i_ctl.clamped ? i_cfg.clamp_gain :
                           (i_ovf ? 32'hFFFF_FFFF : i_quot);
            r_a_gneg    <= !i_ctl.clamped && i_ctl.neg;
            r_a_clamped <= i_ctl.clamped;
            r_a_sat     <= !i_ctl.clamped && i_ovf;

            r_b_p[0]    <= 64'(r_a_carry.ax) * 64'(r_a_gmag);
            r_b_p[1]    <= 64'(r_a_carry.ay) * 64'(r_a_gmag);
            r_b_p[2]    <= 64'(r_a_carry.az) * 64'(r_a_gmag);
            r_b_pd      <= 64'(r_a_carry.deriv) * 64'(r_a_gmag);
            r_b_pix     <= {r_a_carry.pz, r_a_carry.py, r_a_carry.px};
            r_b_gneg    <= r_a_gneg;
            r_b_clamped <= r_a_clamped;
            r_b_sat     <= r_a_sat;

            r_c_v       <= n_v;
            r_c_pix     <= r_b_pix;
            r_c_deriv   <= n_dsat ? 32'hFFFF_FFFF : n_d[31:0];
            r_c_clamped <= r_b_clamped;
            r_c_sat     <= r_b_sat | n_dsat | n_clip[0].sat | n_clip[1].sat | n_clip[2].sat;
        end
    end

    assign o_valid   = r_c_valid;
    assign o_v       = r_c_v;
    assign o_pix     = r_c_pix;
    assign o_deriv   = r_c_deriv;
    assign o_clamped = r_c_clamped;
    assign o_sat     = r_c_sat;
endmodule
`default_nettype wire

[rtl/kis_post.sv]
// Optional constant add, julia add and rotation, five register stages ending in the output register.
`timescale 1ns / 1ps
`default_nettype none
module kis_post #(
    parameter int COORD_FRAC_BITS = 24
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_adv,
    input  wire              i_valid,
    input  wire  [2:0][31:0] i_v,
    input  wire  [2:0][31:0] i_pix,
    input  wire  [31:0]      i_deriv,
    input  wire              i_clamped,
    input  wire              i_sat,
    input  kis_pkg::t_cfg    i_cfg,
    output logic             o_valid,
    output logic [2:0][31:0] o_v,
    output logic [31:0]      o_deriv,
    output logic             o_clamped,
    output logic             o_sat
);
    localparam int JSH = COORD_FRAC_BITS - 16;

    logic              r_valid [5];
    logic [2:0][31:0]  r_v     [5];
    logic [31:0]       r_deriv [5];
    logic              r_clamp [5];
    logic              r_sat   [5];
    logic signed [52:0] r_mp   [3];
    logic signed [52:0] r_rp   [3][3];

    logic              mode_add, mode_julia, mode_rot;
    logic [62:0]       rows [3];
    kis_pkg::t_clip    n_add [3];
    kis_pkg::t_clip    n_jul [3];
    kis_pkg::t_clip    n_rot [3];
    logic signed [63:0] n_rsum [3];
    logic [2:0][31:0]  n_addv, n_julv, n_rotv;
    logic              n_addsat, n_julsat, n_rotsat;

    always_comb begin
        mode_add   = i_cfg.scale_modes[kis_pkg::MODE_ADD];
        mode_julia = i_cfg.scale_modes[kis_pkg::MODE_JULIA];
        mode_rot   = i_cfg.scale_modes[kis_pkg::MODE_ROT];
        rows[0] = i_cfg.rot_x;
        rows[1] = i_cfg.rot_y;
        rows[2] = i_cfg.rot_z;
        for (int i = 0; i < 3; i++) begin
            n_add[i]  = kis_pkg::kis_clip(64'($signed(r_v[0][i])) + 64'(r_mp[i] >>> 16));
            n_addv[i] = mode_add ? n_add[i].val : r_v[0][i];
            n_jul[i]  = kis_pkg::kis_clip(64'($signed(r_v[1][i]))
                        + (64'(kis_pkg::kis_field(i_cfg.julia, i)) <<< JSH));
            n_julv[i] = mode_julia ? n_jul[i].val : r_v[1][i];
            n_rsum[i] = 64'(r_rp[i][0]) + 64'(r_rp[i][1]) + 64'(r_rp[i][2]);
            n_rot[i]  = kis_pkg::kis_clip(n_rsum[i] >>> 16);
            n_rotv[i] = mode_rot ? n_rot[i].val : r_v[3][i];
        end
        n_addsat = mode_add && (n_add[0].sat || n_add[1].sat || n_add[2].sat);
        n_julsat = mode_julia && (n_jul[0].sat || n_jul[1].sat || n_jul[2].sat);
        n_rotsat = mode_rot && (n_rot[0].sat || n_rot[1].sat || n_rot[2].sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 5; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_valid[0] <= i_valid;
            for (int s = 1; s < 5; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_mp[i] <= $signed(i_pix[i]) * kis_pkg::kis_field(i_cfg.cmult, i);
                for (int j = 0; j < 3; j++) begin
                    r_rp[i][j] <= kis_pkg::kis_field(rows[i], j) * $signed(r_v[2][j]);
                end
            end
            r_v[0] <= i_v;
            r_v[1] <= n_addv;
            r_v[2] <= n_julv;
            r_v[3] <= r_v[2];
            r_v[4] <= n_rotv;
            r_deriv[0] <= i_deriv;
            r_clamp[0] <= i_clamped;
            r_sat[0]   <= i_sat;
            for (int s = 1; s < 5; s++) begin
                r_deriv[s] <= r_deriv[s-1];
                r_clamp[s] <= r_clamp[s-1];
            end
            r_sat[1] <= r_sat[0] | n_addsat;
            r_sat[2] <= r_sat[1] | n_julsat;
            r_sat[3] <= r_sat[2];
            r_sat[4] <= r_sat[3] | n_rotsat;
        end
    end

    assign o_valid   = r_valid[4];
    assign o_v       = r_v[4];
    assign o_deriv   = r_deriv[4];
    assign o_clamped = r_clamp[4];
    assign o_sat     = r_sat[4];
endmodule
`default_nettype wire
